// ----- design/wscfp_pkg.sv -----
package wscfp_pkg;

  // command queue between the parser front end and the result back end
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;

  localparam logic [23:0] MaxPayloadRst = 24'd4096;

  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'hA;

  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;
  localparam logic [6:0] PingMaxLen = 7'd125;

  localparam logic [7:0] FinBit   = 8'h80;
  localparam logic [7:0] MaskBit  = 8'h80;

  // pong header: first byte, length byte, four key bytes
  localparam logic [2:0] PongHdrLast = 3'd5;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_PONG      = 3'd1,
    KIND_CLOSE     = 3'd2,
    KIND_OVERSIZE  = 3'd3,
    KIND_PROTO_ERR = 3'd4
  } kind_e;

  // one front-to-back command; pong_hdr expands to six results in the back end
  typedef struct packed {
    logic        pong_hdr;
    kind_e       kind;
    logic [7:0]  byte_val;
    logic [3:0]  opcode;
    logic        last;
    logic [15:0] close_code;
    logic        has_code;
    logic [31:0] key;
  } cmd_t;

  // key byte 0 is bits 31..24
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] kb;
    case (idx)
      2'd0:    kb = key[31:24];
      2'd1:    kb = key[23:16];
      2'd2:    kb = key[15:8];
      default: kb = key[7:0];
    endcase
    return kb;
  endfunction

endpackage

// ----- design/wscfp_front.sv -----
module wscfp_front import wscfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [23:0] cfg_wr_data_i,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] pong_mask_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_DATA,
    PH_PING,
    PH_CLOSE,
    PH_SKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] remain_q, remain_d;
  logic [1:0]  mask_idx_q, mask_idx_d;
  logic [1:0]  close_seen_q, close_seen_d;
  logic [15:0] close_acc_q, close_acc_d;
  logic [31:0] key_q, key_d;
  logic        halted_q, halted_d;
  logic [23:0] max_q;

  logic        hdr_done;
  logic [63:0] hdr_len;
  logic        oversize;
  logic        len_zero;
  logic        pay_last;

  assign oversize = (|hdr_len[63:24]) || (hdr_len[23:0] > max_q);
  assign len_zero = (hdr_len == 64'd0);
  assign pay_last = (remain_q == 64'd1);

  always_comb begin
    phase_d      = phase_q;
    opcode_d     = opcode_q;
    ext_left_d   = ext_left_q;
    remain_d     = remain_q;
    mask_idx_d   = mask_idx_q;
    close_seen_d = close_seen_q;
    close_acc_d  = close_acc_q;
    key_d        = key_q;
    halted_d     = halted_q;
    push_o       = 1'b0;
    cmd_o        = '0;
    cmd_o.opcode = opcode_q;
    hdr_done     = 1'b0;
    hdr_len      = '0;

    if (accept_i && !halted_q) begin
      case (phase_q)
        PH_HDR0: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          if ((rx_byte_i & MaskBit) != 8'd0) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_PROTO_ERR;
            halted_d   = 1'b1;
            phase_d    = PH_HDR0;
          end else if (rx_byte_i[6:0] == Len7Ext16 || rx_byte_i[6:0] == Len7Ext64) begin
            ext_left_d = (rx_byte_i[6:0] == Len7Ext16) ? 4'd2 : 4'd8;
            remain_d   = '0;
            phase_d    = PH_EXT;
          end else begin
            hdr_done = 1'b1;
            hdr_len  = {57'd0, rx_byte_i[6:0]};
          end
        end
        PH_EXT: begin
          remain_d   = {remain_q[55:0], rx_byte_i};
          ext_left_d = ext_left_q - 4'd1;
          if (ext_left_q == 4'd1) begin
            hdr_done = 1'b1;
            hdr_len  = {remain_q[55:0], rx_byte_i};
          end
        end
        PH_DATA, PH_PING, PH_CLOSE, PH_SKIP: begin
          remain_d = remain_q - 64'd1;
          if (phase_q == PH_DATA) begin
            push_o         = 1'b1;
            cmd_o.kind     = KIND_DATA;
            cmd_o.byte_val = rx_byte_i;
            cmd_o.last     = pay_last;
          end else if (phase_q == PH_PING) begin
            push_o         = 1'b1;
            cmd_o.kind     = KIND_PONG;
            cmd_o.byte_val = rx_byte_i ^ key_byte(key_q, mask_idx_q);
            cmd_o.last     = pay_last;
            mask_idx_d     = mask_idx_q + 2'd1;
          end else if (phase_q == PH_CLOSE) begin
            // only the first two payload bytes form the status code
            if (close_seen_q != 2'd2) begin
              close_acc_d  = {close_acc_q[7:0], rx_byte_i};
              close_seen_d = close_seen_q + 2'd1;
            end
            if (pay_last) begin
              push_o         = 1'b1;
              cmd_o.kind     = KIND_CLOSE;
              cmd_o.has_code = (close_seen_d == 2'd2);
              cmd_o.close_code = (close_seen_d == 2'd2) ? close_acc_d : 16'd0;
              halted_d       = 1'b1;
            end
          end
          if (pay_last) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      if (hdr_done) begin
        remain_d = hdr_len;
        if (oversize) begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_OVERSIZE;
          phase_d    = PH_SKIP;
        end else if (opcode_q == OpClose) begin
          close_seen_d = 2'd0;
          close_acc_d  = 16'd0;
          if (len_zero) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_CLOSE;
            halted_d   = 1'b1;
            phase_d    = PH_HDR0;
          end else begin
            phase_d = PH_CLOSE;
          end
        end else if (opcode_q == OpPing) begin
          if ((|hdr_len[63:7]) || (hdr_len[6:0] > PingMaxLen)) begin
            phase_d = PH_SKIP;
          end else begin
            key_d          = pong_mask_i;
            mask_idx_d     = 2'd0;
            push_o         = 1'b1;
            cmd_o.pong_hdr = 1'b1;
            cmd_o.kind     = KIND_PONG;
            cmd_o.byte_val = MaskBit | {1'b0, hdr_len[6:0]};
            cmd_o.last     = len_zero;
            cmd_o.key      = pong_mask_i;
            phase_d        = len_zero ? PH_HDR0 : PH_PING;
          end
        end else begin
          phase_d = len_zero ? PH_HDR0 : PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR0;
      opcode_q     <= '0;
      ext_left_q   <= '0;
      remain_q     <= '0;
      mask_idx_q   <= '0;
      close_seen_q <= '0;
      close_acc_q  <= '0;
      key_q        <= '0;
      halted_q     <= 1'b0;
      max_q        <= MaxPayloadRst;
    end else begin
      phase_q      <= phase_d;
      opcode_q     <= opcode_d;
      ext_left_q   <= ext_left_d;
      remain_q     <= remain_d;
      mask_idx_q   <= mask_idx_d;
      close_seen_q <= close_seen_d;
      close_acc_q  <= close_acc_d;
      key_q        <= key_d;
      halted_q     <= halted_d;
      if (cfg_wr_en_i) begin
        max_q <= cfg_wr_data_i;
      end
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !push_o)
    else $error("command pushed after halt");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt cleared without reset");

  a_ext_only_in_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXT) |-> (ext_left_q != 4'd0))
    else $error("extended length phase with no bytes left");

endmodule

// ----- design/wscfp_queue.sv -----
module wscfp_queue import wscfp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o
);

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count out of range");

endmodule

// ----- design/wscfp_back.sv -----
module wscfp_back import wscfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [3:0]  frame_opcode_o,
  output logic        last_o,
  output logic [15:0] close_code_o,
  output logic        close_has_code_o
);

  logic        valid_q, valid_d;
  logic [2:0]  sub_q, sub_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        last_q, last_d;
  logic [15:0] code_q, code_d;
  logic        has_q, has_d;
  logic        load;
  logic [1:0]  key_idx;

  assign load    = !valid_q || !out_stall_i;
  assign key_idx = sub_q[1:0] - 2'd2;

  always_comb begin
    valid_d  = valid_q;
    sub_d    = sub_q;
    kind_d   = kind_q;
    byte_d   = byte_q;
    opcode_d = opcode_q;
    last_d   = last_q;
    code_d   = code_q;
    has_d    = has_q;
    q_pop_o  = 1'b0;

    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        kind_d   = q_head_i.kind;
        opcode_d = q_head_i.opcode;
        code_d   = q_head_i.close_code;
        has_d    = q_head_i.has_code;
        if (q_head_i.pong_hdr) begin
          case (sub_q)
            3'd0:    byte_d = FinBit | {4'd0, OpPong};
            3'd1:    byte_d = q_head_i.byte_val;
            default: byte_d = key_byte(q_head_i.key, key_idx);
          endcase
          last_d = (sub_q == PongHdrLast) && q_head_i.last;
          if (sub_q == PongHdrLast) begin
            sub_d   = 3'd0;
            q_pop_o = 1'b1;
          end else begin
            sub_d = sub_q + 3'd1;
          end
        end else begin
          byte_d  = q_head_i.byte_val;
          last_d  = q_head_i.last;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= '0;
    end else begin
      valid_q <= valid_d;
      sub_q   <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    opcode_q <= opcode_d;
    last_q   <= last_d;
    code_q   <= code_d;
    has_q    <= has_d;
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = kind_q;
  assign byte_value_o     = byte_q;
  assign frame_opcode_o   = opcode_q;
  assign last_o           = last_q;
  assign close_code_o     = code_q;
  assign close_has_code_o = has_q;

  a_hdr_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_q != 3'd0) |-> (q_valid_i && q_head_i.pong_hdr))
    else $error("pong header expansion lost its queue entry");

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q <= PongHdrLast)
    else $error("pong header step out of range");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> valid_q)
    else $error("queue entry popped without a result");

endmodule

// ----- design/websocket_client_frame_parser.sv -----
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------------
// rx        | in        | in_valid_i / in_stall_o   | rx_byte_i, pong_mask_i
// result    | out       | out_valid_o / out_stall_i | kind_o, byte_value_o, frame_opcode_o,
//           |           |                           | last_o, close_code_o, close_has_code_o
// config    | in        | cfg_wr_en_i               | cfg_wr_data_i (max_payload)
//
// One received byte per cycle while in_stall_o is low; the parser front end turns each
// byte into at most one command, which passes through the command queue into the result
// register. A pong header command yields six results in the back end, all other commands one.
// in_stall_o rises only when the four-entry command queue is full.
// Reset is asynchronous; max_payload resets to 4096 and there is no clearing pass.
// After a close or protocol error, bytes are still taken but yield no results until reset.
module websocket_client_frame_parser import wscfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [23:0] cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] pong_mask_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [3:0]  frame_opcode_o,
  output logic        last_o,
  output logic [15:0] close_code_o,
  output logic        close_has_code_o
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  wscfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .pong_mask_i   (pong_mask_i),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  wscfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  wscfp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .byte_value_o     (byte_value_o),
    .frame_opcode_o   (frame_opcode_o),
    .last_o           (last_o),
    .close_code_o     (close_code_o),
    .close_has_code_o (close_has_code_o)
  );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import wscfp_pkg::*;

  localparam int SettleCycles = 16;
  localparam int LongHold     = 300;
  localparam int QuietLimit   = 4000;
  localparam int MaxPrinted   = 50;

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_EXTLEN, ST_DATA, ST_PING, ST_CLOSE, ST_SKIP
  } parse_st_e;

  typedef enum int {ENC_7BIT, ENC_16BIT, ENC_64BIT} len_enc_e;

  typedef enum int {
    END_MASKED, END_CLOSE_EMPTY, END_CLOSE_SHORT, END_CLOSE_CODE, END_HUGE_LEN
  } end_event_e;

  typedef struct {
    logic [7:0]  data;
    logic [31:0] key;
  } rx_item_t;

  typedef struct {
    kind_e       kind;
    logic [7:0]  value;
    logic [3:0]  opcode;
    logic        last;
    logic [15:0] code;
    logic        has_code;
  } parse_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_wr_en_i   = 1'b0;
  logic [23:0] cfg_wr_data_i = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i     = '0;
  logic [31:0] pong_mask_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  byte_value_o;
  logic [3:0]  frame_opcode_o;
  logic        last_o;
  logic [15:0] close_code_o;
  logic        close_has_code_o;

  websocket_client_frame_parser u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .pong_mask_i      (pong_mask_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .byte_value_o     (byte_value_o),
    .frame_opcode_o   (frame_opcode_o),
    .last_o           (last_o),
    .close_code_o     (close_code_o),
    .close_has_code_o (close_has_code_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  rx_item_t      rx_bytes_q[$];
  parse_result_t parsed_q[$];
  rx_item_t      drv_item;
  parse_result_t want_r;

  // stimulus control
  logic [23:0] cap_now;
  bit          send_gaps;
  int          stall_pct;
  int          hold_reqs;
  int          hold_seen;
  int          hold_left;
  int          gap_left;
  int          burst_left;
  end_event_e  end_ev;

  int err_cnt;
  int n_queued;
  int n_frames;
  int n_bytes;
  int n_results;
  int n_in_stalls;
  int quiet_cycles;

  // parser state mirror
  parse_st_e   m_st;
  logic [3:0]  m_op;
  logic [3:0]  m_ext_left;
  logic [63:0] m_remain;
  logic [1:0]  m_kidx;
  logic [1:0]  m_close_n;
  logic [15:0] m_close_code;
  logic [31:0] m_key;
  logic        m_halted;
  logic [23:0] m_cap;

  task automatic report_mismatch(input string msg);
    if (err_cnt < MaxPrinted) $display("%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic [7:0] key_lane(input logic [1:0] idx);
    return m_key[8 * (3 - idx) +: 8];
  endfunction

  task automatic add_result(input kind_e k, input logic [7:0] v, input logic lst,
                            input logic [15:0] code, input logic has);
    parse_result_t r;
    r.kind     = k;
    r.value    = v;
    r.opcode   = m_op;
    r.last     = lst;
    r.code     = code;
    r.has_code = has;
    parsed_q.push_back(r);
  endtask

  task automatic header_complete(input logic [63:0] len, input logic [31:0] pm);
    int i;
    m_remain = len;
    if (len > 64'(m_cap)) begin
      add_result(KIND_OVERSIZE, 8'h00, 1'b0, 16'h0, 1'b0);
      m_st = ST_SKIP;
    end else if (m_op == OpClose) begin
      m_close_n    = '0;
      m_close_code = '0;
      if (len == 0) begin
        add_result(KIND_CLOSE, 8'h00, 1'b0, 16'h0, 1'b0);
        m_halted = 1'b1;
        m_st     = ST_HDR0;
      end else begin
        m_st = ST_CLOSE;
      end
    end else if (m_op == OpPing) begin
      if (len > 64'(PingMaxLen)) begin
        m_st = ST_SKIP;  // too long to echo, drop silently
      end else begin
        m_key  = pm;
        m_kidx = '0;
        add_result(KIND_PONG, FinBit | {4'h0, OpPong}, 1'b0, 16'h0, 1'b0);
        add_result(KIND_PONG, MaskBit | {1'b0, len[6:0]}, 1'b0, 16'h0, 1'b0);
        for (i = 0; i < 4; i++) begin
          add_result(KIND_PONG, key_lane(2'(i)), (i == 3) && (len == 0), 16'h0, 1'b0);
        end
        m_st = (len != 0) ? ST_PING : ST_HDR0;
      end
    end else begin
      m_st = (len != 0) ? ST_DATA : ST_HDR0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic [31:0] pm);
    logic [6:0] len7;
    logic       lst;
    if (!m_halted) begin
      case (m_st)
        ST_HDR1: begin
          len7 = b[6:0];
          if ((b & MaskBit) != 0) begin
            add_result(KIND_PROTO_ERR, 8'h00, 1'b0, 16'h0, 1'b0);
            m_halted = 1'b1;
            m_st     = ST_HDR0;
          end else if (len7 == Len7Ext16 || len7 == Len7Ext64) begin
            m_ext_left = (len7 == Len7Ext16) ? 4'd2 : 4'd8;
            m_remain   = '0;
            m_st       = ST_EXTLEN;
          end else begin
            header_complete(64'(len7), pm);
          end
        end
        ST_EXTLEN: begin
          m_remain = {m_remain[55:0], b};
          m_ext_left--;
          if (m_ext_left == 0) header_complete(m_remain, pm);
        end
        ST_DATA, ST_PING, ST_CLOSE, ST_SKIP: begin
          m_remain--;
          lst = (m_remain == 0);
          if (m_st == ST_DATA) begin
            add_result(KIND_DATA, b, lst, 16'h0, 1'b0);
          end else if (m_st == ST_PING) begin
            add_result(KIND_PONG, b ^ key_lane(m_kidx), lst, 16'h0, 1'b0);
            m_kidx++;
          end else if (m_st == ST_CLOSE) begin
            // only the first two payload bytes form the status code
            if (m_close_n < 2) begin
              m_close_code = {m_close_code[7:0], b};
              m_close_n++;
            end
            if (lst) begin
              if (m_close_n >= 2) add_result(KIND_CLOSE, 8'h00, 1'b0, m_close_code, 1'b1);
              else add_result(KIND_CLOSE, 8'h00, 1'b0, 16'h0, 1'b0);
              m_halted = 1'b1;
            end
          end
          if (lst) m_st = ST_HDR0;
        end
        default: begin
          m_op = b[3:0];
          m_st = ST_HDR1;
        end
      endcase
    end
  endtask

  task automatic push_rx(input logic [7:0] b);
    rx_bytes_q.push_back('{data: b, key: $urandom()});
    n_queued++;
  endtask

  // FIN and RSV bits are random on every frame
  task automatic queue_frame(input logic [3:0] op, input logic [63:0] len,
                             input len_enc_e enc, input logic masked, input int body);
    logic [7:0] b1;
    int         i;
    b1 = masked ? MaskBit : 8'h00;
    push_rx({4'($urandom()), op});
    case (enc)
      ENC_7BIT: push_rx(b1 | {1'b0, len[6:0]});
      ENC_16BIT: begin
        push_rx(b1 | {1'b0, Len7Ext16});
        push_rx(len[15:8]);
        push_rx(len[7:0]);
      end
      default: begin
        push_rx(b1 | {1'b0, Len7Ext64});
        for (i = 7; i >= 0; i--) push_rx(len[8 * i +: 8]);
      end
    endcase
    repeat (body) push_rx(8'($urandom()));
    n_frames++;
  endtask

  task automatic queue_random_frame();
    logic [3:0] op;
    int         r;
    int         len;
    len_enc_e   enc;
    r = $urandom_range(0, 19);
    if (r < 8) op = 4'($urandom_range(0, 2));
    else if (r < 11) op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7))
                                                : 4'($urandom_range(10, 15));
    else if (r < 17) op = OpPing;
    else op = OpClose;
    r = $urandom_range(0, 9);
    if (r < 6) len = $urandom_range(0, 8);
    else if (r < 8) len = $urandom_range(9, 40);
    else if (cap_now < 64) len = int'(cap_now) + $urandom_range(0, 2) - 1;
    else len = $urandom_range(0, 3);
    if (len < 0) len = 0;
    // a close within capacity would halt the parser, so mid-run closes are oversize
    if (op == OpClose && len <= int'(cap_now)) begin
      if (cap_now < 64) len = int'(cap_now) + 1 + $urandom_range(0, 2);
      else op = 4'h2;
    end
    if (len < 126) begin
      r   = $urandom_range(0, 5);
      enc = (r < 4) ? ENC_7BIT : len_enc_e'(r - 3);
    end else begin
      enc = len_enc_e'($urandom_range(1, 2));
    end
    queue_frame(op, 64'(len), enc, 1'b0, len);
  endtask

  task automatic fill_random(input int nbytes);
    int start;
    start = n_queued;
    while (n_queued - start < nbytes) queue_random_frame();
  endtask

  // close and protocol error halt the block and a huge oversize length skips the rest, so exactly one ends the run
  task automatic queue_final_event();
    int len;
    end_ev = end_event_e'($urandom_range(0, 4));
    case (end_ev)
      END_MASKED: queue_frame(4'($urandom()), 64'($urandom_range(0, 127)), ENC_7BIT, 1'b1, 0);
      END_CLOSE_EMPTY: queue_frame(OpClose, 64'd0, ENC_7BIT, 1'b0, 0);
      END_CLOSE_SHORT: queue_frame(OpClose, 64'd1, len_enc_e'($urandom_range(0, 2)), 1'b0, 1);
      END_CLOSE_CODE: begin
        len = $urandom_range(2, 6);
        queue_frame(OpClose, 64'(len), len_enc_e'($urandom_range(0, 2)), 1'b0, len);
      end
      default: queue_frame(4'($urandom_range(0, 2)), {1'b1, 31'($urandom()), 32'($urandom())},
                           ENC_64BIT, 1'b0, 0);
    endcase
    repeat (6) push_rx(8'($urandom()));
  endtask

  task automatic write_max_payload(input logic [23:0] v);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    cap_now = v;
  endtask

  task automatic wait_idle();
    while (rx_bytes_q.size() != 0 || in_valid_i || parsed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // sender: bursts and gaps, predicts on every accepted transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      gap_left     = 0;
      burst_left   = 1;
      m_st         = ST_HDR0;
      m_op         = '0;
      m_ext_left   = '0;
      m_remain     = '0;
      m_kidx       = '0;
      m_close_n    = '0;
      m_close_code = '0;
      m_key        = '0;
      m_halted     = 1'b0;
      m_cap        = MaxPayloadRst;
    end else begin
      if (cfg_wr_en_i) m_cap = cfg_wr_data_i;
      if (in_valid_i && in_stall_o) n_in_stalls++;
      if (in_valid_i && !in_stall_o) begin
        parse_byte(rx_byte_i, pong_mask_i);
        n_bytes++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          drv_item = rx_bytes_q.pop_front();
          rx_byte_i   <= drv_item.data;
          pong_mask_i <= drv_item.key;
          in_valid_i  <= 1'b1;
          if (send_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 12);
              gap_left   = $urandom_range(1, 8);
            end
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results in order, stalls randomly or for a long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (parsed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: kind %0d byte %02h opcode %0h",
                                    kind_o, byte_value_o, frame_opcode_o));
        end else begin
          want_r = parsed_q.pop_front();
          if (kind_o !== want_r.kind)
            report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                      n_results, kind_o, want_r.kind));
          if (byte_value_o !== want_r.value)
            report_mismatch($sformatf("result %0d byte %02h, expected %02h",
                                      n_results, byte_value_o, want_r.value));
          if (frame_opcode_o !== want_r.opcode)
            report_mismatch($sformatf("result %0d opcode %0h, expected %0h",
                                      n_results, frame_opcode_o, want_r.opcode));
          if (last_o !== want_r.last)
            report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                      n_results, last_o, want_r.last));
          if (close_code_o !== want_r.code)
            report_mismatch($sformatf("result %0d close code %04h, expected %04h",
                                      n_results, close_code_o, want_r.code));
          if (close_has_code_o !== want_r.has_code)
            report_mismatch($sformatf("result %0d close_has_code %0b, expected %0b",
                                      n_results, close_has_code_o, want_r.has_code));
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("no transaction for %0d cycles", QuietLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int plen;
    cap_now   = MaxPayloadRst;
    send_gaps = 1'b0;
    stall_pct = 0;
    hold_reqs = 0;
    hold_seen = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: payload extremes, reserved opcode empty frame, pings, long encodings
    queue_frame(4'h1, 64'd2, ENC_7BIT, 1'b0, 0);
    push_rx(8'hFF);
    push_rx(8'h00);
    queue_frame(4'hF, 64'd0, ENC_7BIT, 1'b0, 0);
    queue_frame(OpPing, 64'd0, ENC_7BIT, 1'b0, 0);
    queue_frame(OpPing, 64'd3, ENC_16BIT, 1'b0, 3);
    queue_frame(4'h0, 64'd1, ENC_64BIT, 1'b0, 0);
    push_rx(8'hA5);
    wait_idle();

    // zero capacity: every non-empty frame is dropped as oversize
    write_max_payload(24'd0);
    send_gaps = 1'b1;
    stall_pct = 20;
    fill_random(8);
    wait_idle();

    write_max_payload(24'($urandom_range(1, 12)));
    send_gaps = 1'b0;
    stall_pct = 50;
    fill_random(8);
    wait_idle();

    // full capacity: data burst against a long receiver hold, then a ping past the echo limit
    write_max_payload(24'hFF_FFFF);
    stall_pct = 0;
    queue_frame(4'h2, 64'd8, ENC_7BIT, 1'b0, 8);
    hold_reqs <= hold_reqs + 1;
    plen = 126;
    queue_frame(OpPing, 64'(plen), ENC_16BIT, 1'b0, plen);
    wait_idle();

    write_max_payload(24'($urandom_range(8, 40)));
    send_gaps = 1'b1;
    stall_pct = 30;
    fill_random(8);
    queue_final_event();
    wait_idle();

    $display("%0d frames, %0d bytes taken, %0d results checked, %0d cycles of input stall",
             n_frames, n_bytes, n_results, n_in_stalls);
    $display("capacities 4096, 0, small, max and %0d; stream ended by %s",
             cap_now, end_ev.name());
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
